### rtl/core/console_cpu_bus_decoder_assert.svh
// Assertion macros for the console CPU bus decoder.
// Expects clk and arst_n in the scope of each use.
`ifndef CONSOLE_CPU_BUS_DECODER_ASSERT_SVH
`define CONSOLE_CPU_BUS_DECODER_ASSERT_SVH

// same-cycle implication
`define CCBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ccbd_pkg.sv
// Package for the console CPU bus decoder: item types, target codes,
// address map constants and the work RAM power-up pattern. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccbd_pkg;

	localparam int WORK_RAM_BYTES = 2048;
	localparam int SAVE_RAM_BYTES = 8192;
	localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);
	localparam int SRAM_AW        = $clog2(SAVE_RAM_BYTES);

	// target codes
	localparam logic [3:0] T_RAM      = 4'd0;
	localparam logic [3:0] T_PRGRAM   = 4'd1;
	localparam logic [3:0] T_PAD      = 4'd2;
	localparam logic [3:0] T_PPU      = 4'd3;
	localparam logic [3:0] T_APU      = 4'd4;
	localparam logic [3:0] T_ROM      = 4'd5;
	localparam logic [3:0] T_MAPPER   = 4'd6;
	localparam logic [3:0] T_DMA      = 4'd7;
	localparam logic [3:0] T_UNMAPPED = 4'd8;

	// bus operation codes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// config register indexes
	localparam int         CFG_IDX_W          = 2;
	localparam logic [1:0] CFG_ROM_BANK_MASK  = 2'd0;
	localparam logic [1:0] CFG_ROM_BANK_SHIFT = 2'd1;

	// address map
	localparam logic [15:0] ADDR_PPU_BASE = 16'h2000;
	localparam logic [15:0] ADDR_APU_BASE = 16'h4000;
	localparam logic [15:0] ADDR_GAP_BASE = 16'h4018;
	localparam logic [15:0] ADDR_PRG_BASE = 16'h6000;
	localparam logic [15:0] ADDR_ROM_BASE = 16'h8000;
	localparam logic [15:0] ADDR_PAD      = 16'h4016;
	localparam logic [15:0] ADDR_OAM_DMA  = 16'h4014;

	localparam logic [9:0] DMA_STALL   = 10'd513;
	localparam logic [3:0] PAD_BITS    = 4'd8;
	localparam logic [3:0] SHIFT_RESET = 4'd15;

	typedef struct packed {
		logic        operation;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [7:0]  buttons;
	} ccbd_in_t;

	typedef struct packed {
		logic [3:0]  target;
		logic [7:0]  read_data;
		logic [4:0]  device_register;
		logic [2:0]  rom_bank;
		logic [14:0] rom_offset;
		logic [7:0]  dma_page;
		logic [9:0]  stall_cycles;
	} ccbd_out_t;

	// power-up contents of work RAM
	function automatic logic [7:0] wram_init(input logic [WRAM_AW-1:0] idx);
		logic [7:0] v;
		unique case (idx)
			WRAM_AW'(8):  v = 8'hF7;
			WRAM_AW'(9):  v = 8'hEF;
			WRAM_AW'(10): v = 8'hDF;
			WRAM_AW'(15): v = 8'hBF;
			default:      v = 8'hFF;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### rtl/core/ccbd_ram.sv
// Generic single-port synchronous RAM, read-first, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ccbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/console_cpu_bus_decoder.sv
// Console CPU bus decoder top level: address decode, pad port, work RAM
// and PRG-RAM. Depends on ccbd_pkg, ccbd_ram and the assertion macro header.
//
//  channel | signals                        | direction | item
//  --------+--------------------------------+-----------+---------------------
//  in      | in_valid, in_ready, in_item    | to block  | one CPU bus access
//  out     | out_valid, out_ready, out_item | from block| decoded result
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | to block | reg write
//
// An item enters at accept and the RAM is read or written in that cycle; the
// decoded item and RAM read data pass through s1 into the output register. One
// item per cycle sustained while the output is not stalled, set by the single
// RAM port and s1 -> out stage. After reset both RAMs are swept to power-up
// values, one entry a cycle over the PRG-RAM depth, with in_ready low; cfg
// writes still taken. A stalled output holds s1, which holds in_ready low.
`timescale 1ns / 1ps
`default_nettype none

`include "console_cpu_bus_decoder_assert.svh"

module console_cpu_bus_decoder
	import ccbd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ccbd_in_t             in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output ccbd_out_t                 out_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	// configuration
	logic [15:0] bank_mask_q;
	logic [3:0]  bank_shift_q;

	// clear sweep
	logic               clear_q;
	logic [SRAM_AW-1:0] clr_q;

	// pad port
	logic [7:0] pad_latch_q;
	logic [3:0] pad_idx_q;

	// stage 1 and output register
	logic      valid_s1;
	ccbd_out_t res_s1;
	logic      wram_rd_s1;
	logic      sram_rd_s1;
	ccbd_out_t res_mux;
	logic      out_valid_q;
	ccbd_out_t out_q;

	logic in_fire;
	logic adv;

	// decode of the incoming item
	ccbd_out_t res_d;
	logic      is_wram;
	logic      is_sram;
	logic      is_pad;
	logic      is_wr;
	logic [15:0] off_mask;
	logic [15:0] bank_full;

	// RAM ports
	logic               wram_en, wram_we;
	logic [WRAM_AW-1:0] wram_addr;
	logic [7:0]         wram_wdata, wram_rdata;
	logic               sram_en, sram_we;
	logic [SRAM_AW-1:0] sram_addr;
	logic [7:0]         sram_wdata, sram_rdata;

	assign cfg_ready = 1'b1;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !clear_q && (!valid_s1 || adv);
	assign in_fire  = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign is_wr     = (in_item.operation == OP_WRITE);
	assign off_mask  = ~(16'hFFFF << bank_shift_q);
	assign bank_full = (in_item.address & bank_mask_q) >> bank_shift_q;

	always_comb begin
		res_d   = '0;
		is_wram = 1'b0;
		is_sram = 1'b0;
		is_pad  = 1'b0;
		priority if (in_item.address < ADDR_PPU_BASE) begin
			res_d.target = T_RAM;
			is_wram      = 1'b1;
		end else if (in_item.address < ADDR_APU_BASE) begin
			res_d.target          = T_PPU;
			res_d.device_register = {2'b00, in_item.address[2:0]};
		end else if (in_item.address < ADDR_GAP_BASE) begin
			priority if (in_item.address == ADDR_PAD) begin
				res_d.target = T_PAD;
				is_pad       = 1'b1;
				if (!is_wr) begin
					// past the eighth bit the port reads back 1
					res_d.read_data = (pad_idx_q < PAD_BITS) ?
						{7'd0, pad_latch_q[pad_idx_q[2:0]]} : 8'd1;
				end
			end else if (is_wr && in_item.address == ADDR_OAM_DMA) begin
				res_d.target       = T_DMA;
				res_d.dma_page     = in_item.write_data;
				res_d.stall_cycles = DMA_STALL;
			end else begin
				res_d.target          = T_APU;
				res_d.device_register = in_item.address[4:0];
			end
		end else if (in_item.address < ADDR_PRG_BASE) begin
			res_d.target = T_UNMAPPED;
		end else if (in_item.address < ADDR_ROM_BASE) begin
			res_d.target = T_PRGRAM;
			is_sram      = 1'b1;
		end else begin
			res_d.target     = is_wr ? T_MAPPER : T_ROM;
			res_d.rom_bank   = bank_full[2:0];
			res_d.rom_offset = in_item.address[14:0] & off_mask[14:0];
		end
	end

	// RAM access: sweep owns the ports until done, then the accepted item
	always_comb begin
		if (clear_q) begin
			wram_en    = (clr_q[SRAM_AW-1:WRAM_AW] == '0);
			wram_we    = 1'b1;
			wram_addr  = clr_q[WRAM_AW-1:0];
			wram_wdata = wram_init(clr_q[WRAM_AW-1:0]);
			sram_en    = 1'b1;
			sram_we    = 1'b1;
			sram_addr  = clr_q;
			sram_wdata = 8'd0;
		end else begin
			wram_en    = in_fire && is_wram;
			wram_we    = is_wr;
			wram_addr  = in_item.address[WRAM_AW-1:0];
			wram_wdata = in_item.write_data;
			sram_en    = in_fire && is_sram;
			sram_we    = is_wr;
			sram_addr  = in_item.address[SRAM_AW-1:0];
			sram_wdata = in_item.write_data;
		end
	end

	ccbd_ram #(
		.WIDTH (8),
		.DEPTH (WORK_RAM_BYTES)
	) u_wram (
		.clk   (clk),
		.en    (wram_en),
		.we    (wram_we),
		.addr  (wram_addr),
		.wdata (wram_wdata),
		.rdata (wram_rdata)
	);

	ccbd_ram #(
		.WIDTH (8),
		.DEPTH (SAVE_RAM_BYTES)
	) u_sram (
		.clk   (clk),
		.en    (sram_en),
		.we    (sram_we),
		.addr  (sram_addr),
		.wdata (sram_wdata),
		.rdata (sram_rdata)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_mask_q  <= 16'd0;
			bank_shift_q <= SHIFT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_ROM_BANK_MASK) begin
				bank_mask_q <= cfg_data;
			end else if (cfg_index == CFG_ROM_BANK_SHIFT) begin
				bank_shift_q <= cfg_data[3:0];
			end
		end
	end

	// clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q <= 1'b1;
			clr_q   <= '0;
		end else if (clear_q) begin
			clr_q <= clr_q + SRAM_AW'(1);
			if (clr_q == '1) begin
				clear_q <= 1'b0;
			end
		end
	end

	// pad latch and shift index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_latch_q <= 8'd0;
			pad_idx_q   <= 4'd0;
		end else if (in_fire && is_pad) begin
			if (is_wr) begin
				if (in_item.write_data[0]) begin
					pad_latch_q <= in_item.buttons;
				end
				pad_idx_q <= 4'd0;
			end else if (pad_idx_q < PAD_BITS) begin
				pad_idx_q <= pad_idx_q + 4'd1;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_s1     <= res_d;
			wram_rd_s1 <= is_wram && !is_wr;
			sram_rd_s1 <= is_sram && !is_wr;
		end
	end

	// RAM read data joins the decoded result on its way out
	always_comb begin
		res_mux = res_s1;
		if (wram_rd_s1) begin
			res_mux.read_data = wram_rdata;
		end else if (sram_rd_s1) begin
			res_mux.read_data = sram_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_q <= res_mux;
		end
	end

	`CCBD_ASSERT_NOW(a_no_out_in_clear, clear_q, !out_valid_q, "result during RAM sweep")
	`CCBD_ASSERT_NOW(a_pad_idx_range, 1'b1, pad_idx_q <= PAD_BITS, "pad index past eight")
	`CCBD_ASSERT_NEXT(a_accept_to_s1, in_fire, valid_s1, "accepted item lost before s1")
	`CCBD_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(res_s1), "s1 item dropped")
	`CCBD_ASSERT_NOW(a_dma_stall, out_valid_q && out_q.target == T_DMA,
		out_q.stall_cycles == DMA_STALL, "dma result without stall")

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking bench for the console CPU bus decoder: bus accesses in, decoded results out.
// Depends on ccbd_pkg and console_cpu_bus_decoder; the decoder is predicted in a scoreboard class.
`timescale 1ns / 1ps

module tb_top;
	import ccbd_pkg::*;

	// indexes past the register list, written to see they are ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	localparam int PIPE_LATENCY    = 2;
	localparam int IDLE_PERCENT    = 24;
	localparam int NUM_SETTINGS    = 9;
	localparam int ITEMS_PER_PHASE = 140;
	localparam int STEADY_PHASE    = 2;

	// fixed ROM map settings; the last ones are drawn at random
	localparam logic [15:0] MAP_MASK  [NUM_SETTINGS] = '{16'h0000, 16'hFFFF, 16'hFFFF,
		16'hE000, 16'hC000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
	localparam logic [3:0]  MAP_SHIFT [NUM_SETTINGS] = '{4'd15, 4'd15, 4'd13,
		4'd13, 4'd14, 4'd0, 4'd0, 4'd0, 4'd0};
	localparam int NUM_FIXED = 7;

	// Keeps its own copy of the decoder state and the queue of decoded results
	// still owed by the block.
	class bus_map_scoreboard;
		logic [7:0]  work_ram [WORK_RAM_BYTES];
		logic [7:0]  save_ram [SAVE_RAM_BYTES];
		logic [7:0]  pad_latch;
		logic [3:0]  pad_bit;
		logic [15:0] bank_mask;
		logic [3:0]  bank_shift;
		ccbd_out_t   owed_decodes [$];
		int          errors;
		int          checked;
		int          target_hits [9];

		function new();
			foreach (work_ram[i])
				work_ram[i] = 8'hFF;
			work_ram[8]  = 8'hF7;
			work_ram[9]  = 8'hEF;
			work_ram[10] = 8'hDF;
			work_ram[15] = 8'hBF;
			foreach (save_ram[i])
				save_ram[i] = 8'h00;
			pad_latch  = '0;
			pad_bit    = '0;
			bank_mask  = '0;
			bank_shift = SHIFT_RESET;
			errors     = 0;
			checked    = 0;
			foreach (target_hits[i])
				target_hits[i] = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			if (idx == CFG_ROM_BANK_MASK)
				bank_mask = data;
			else if (idx == CFG_ROM_BANK_SHIFT)
				bank_shift = data[3:0];
		endfunction

		// decode one access against the memory map and update RAM / pad state
		function ccbd_out_t decode_access(ccbd_in_t acc);
			ccbd_out_t   r;
			logic [15:0] a;
			logic [31:0] bank;
			logic [31:0] off;
			logic        wr;
			r  = '0;
			a  = acc.address;
			wr = (acc.operation == OP_WRITE);
			if (a < ADDR_PPU_BASE) begin
				r.target = T_RAM;
				if (wr)
					work_ram[a[WRAM_AW-1:0]] = acc.write_data;
				else
					r.read_data = work_ram[a[WRAM_AW-1:0]];
			end else if (a < ADDR_APU_BASE) begin
				r.target          = T_PPU;
				r.device_register = {2'b00, a[2:0]};
			end else if (a < ADDR_GAP_BASE) begin
				if (a == ADDR_PAD) begin
					r.target = T_PAD;
					if (wr) begin
						if (acc.write_data[0])
							pad_latch = acc.buttons;
						pad_bit = '0;
					end else if (pad_bit < PAD_BITS) begin
						r.read_data = {7'b0, pad_latch[pad_bit[2:0]]};
						pad_bit++;
					end else begin
						r.read_data = 8'h01;
					end
				end else if (wr && a == ADDR_OAM_DMA) begin
					r.target       = T_DMA;
					r.dma_page     = acc.write_data;
					r.stall_cycles = DMA_STALL;
				end else begin
					r.target          = T_APU;
					r.device_register = 5'(a - ADDR_APU_BASE);
				end
			end else if (a < ADDR_PRG_BASE) begin
				r.target = T_UNMAPPED;
			end else if (a < ADDR_ROM_BASE) begin
				r.target = T_PRGRAM;
				if (wr)
					save_ram[SRAM_AW'(a - ADDR_PRG_BASE)] = acc.write_data;
				else
					r.read_data = save_ram[SRAM_AW'(a - ADDR_PRG_BASE)];
			end else begin
				r.target     = wr ? T_MAPPER : T_ROM;
				bank         = ({16'b0, a} & {16'b0, bank_mask}) >> bank_shift;
				off          = {16'b0, a} & ((32'd1 << bank_shift) - 32'd1);
				r.rom_bank   = bank[2:0];
				r.rom_offset = off[14:0];
			end
			return r;
		endfunction

		function void note_access(ccbd_in_t acc);
			ccbd_out_t r;
			r = decode_access(acc);
			target_hits[r.target]++;
			owed_decodes.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
			end
		endfunction

		function void check_result(ccbd_out_t got);
			ccbd_out_t want;
			if (owed_decodes.size() == 0) begin
				errors++;
				$display("%0t: result with none owed, expected nothing actual 0x%0h", $time, got);
				return;
			end
			want = owed_decodes.pop_front();
			checked++;
			compare_field("target", 32'(want.target), 32'(got.target));
			compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
			compare_field("device_register", 32'(want.device_register),
				32'(got.device_register));
			compare_field("rom_bank", 32'(want.rom_bank), 32'(got.rom_bank));
			compare_field("rom_offset", 32'(want.rom_offset), 32'(got.rom_offset));
			compare_field("dma_page", 32'(want.dma_page), 32'(got.dma_page));
			compare_field("stall_cycles", 32'(want.stall_cycles), 32'(got.stall_cycles));
		endfunction

		function int pending();
			return owed_decodes.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	ccbd_in_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	ccbd_out_t            out_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data  = '0;

	// no idling on either side while this is set
	logic steady = 1'b0;

	bus_map_scoreboard sb;
	int                items_sent = 0;

	console_cpu_bus_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: drops ready in about a quarter of the cycles
	always @(posedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// monitor: every handshake is sampled at the edge where it completes
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_access(in_item);
			if (out_valid && out_ready)
				sb.check_result(out_item);
		end
	end

	function automatic ccbd_in_t make_access(logic op, logic [15:0] addr, logic [7:0] data,
		logic [7:0] btn);
		ccbd_in_t acc;
		acc.operation  = op;
		acc.address    = addr;
		acc.write_data = data;
		acc.buttons    = btn;
		return acc;
	endfunction

	// one random access, weighted toward the mapped regions
	function automatic ccbd_in_t random_access();
		ccbd_in_t acc;
		int       pick;
		acc.operation  = 1'($urandom_range(0, 1));
		acc.write_data = 8'($urandom);
		acc.buttons    = 8'($urandom);
		pick           = $urandom_range(0, 99);
		if (pick < 25) begin
			acc.address = 16'($urandom_range(0, 16'h1FFF));
			// crowd half the RAM accesses into 16 bytes so reads find writes
			if ($urandom_range(0, 1))
				acc.address[10:4] = '0;
		end else if (pick < 35) begin
			acc.address = ADDR_PPU_BASE + 16'($urandom_range(0, 16'h1FFF));
		end else if (pick < 47) begin
			acc.address = ADDR_APU_BASE + 16'($urandom_range(0, 23));
		end else if (pick < 52) begin
			acc.operation = OP_WRITE;
			acc.address   = ADDR_OAM_DMA;
		end else if (pick < 56) begin
			acc.address = ADDR_GAP_BASE + 16'($urandom_range(0, 16'h5FFF - 16'h4018));
		end else if (pick < 78) begin
			acc.address = ADDR_PRG_BASE + 16'($urandom_range(0, 16'h1FFF));
			if ($urandom_range(0, 1))
				acc.address[12:4] = '0;
		end else if (pick < 92) begin
			acc.address = ADDR_ROM_BASE + 16'($urandom_range(0, 16'h7FFF));
		end else begin
			acc.address = 16'($urandom);
		end
		return acc;
	endfunction

	// sender: random idle cycles, then hold the item until it is taken
	task automatic send_item(ccbd_in_t acc);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= acc;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	// strobe, maybe a release write, then a run of serial reads, often past the eighth bit
	task automatic pad_sequence();
		int reads;
		reads = $urandom_range(4, 11);
		send_item(make_access(OP_WRITE, ADDR_PAD, 8'($urandom) | 8'h01, 8'($urandom)));
		if ($urandom_range(0, 3) == 0)
			send_item(make_access(OP_WRITE, ADDR_PAD, 8'($urandom) & 8'hFE, 8'($urandom)));
		repeat (reads)
			send_item(make_access(OP_READ, ADDR_PAD, 8'($urandom), 8'($urandom)));
	endtask

	// sender holds off until every owed result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// block is idle here; upper bits of the shift write are junk on purpose
	task automatic configure(logic [15:0] mask, logic [3:0] shift);
		if ($urandom_range(0, 1))
			write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
		write_reg(CFG_ROM_BANK_MASK, mask);
		write_reg(CFG_ROM_BANK_SHIFT, {12'($urandom), shift});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int          p;
		int          start;
		logic [15:0] mask;
		logic [3:0]  shift;
		sb = new();
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset ROM map; first item waits out the RAM sweep
		send_item(make_access(OP_READ, 16'h0008, 8'h00, 8'h00));   // power-up pattern byte
		send_item(make_access(OP_READ, 16'h080F, 8'hFF, 8'hFF));   // mirror of byte 15
		send_item(make_access(OP_READ, 16'h1FFF, 8'h00, 8'h00));
		send_item(make_access(OP_WRITE, 16'h07FF, 8'hA5, 8'h00));
		send_item(make_access(OP_READ, 16'h1FFF, 8'h00, 8'h00));   // mirror sees the write
		send_item(make_access(OP_READ, 16'h2000, 8'h00, 8'h00));
		send_item(make_access(OP_WRITE, 16'h3FFF, 8'hFF, 8'hFF));
		send_item(make_access(OP_READ, ADDR_APU_BASE, 8'h00, 8'h00));
		send_item(make_access(OP_WRITE, 16'h4017, 8'h55, 8'h00));
		send_item(make_access(OP_READ, ADDR_OAM_DMA, 8'h00, 8'h00)); // read goes to apu
		send_item(make_access(OP_WRITE, ADDR_OAM_DMA, 8'hFF, 8'h00));
		send_item(make_access(OP_WRITE, ADDR_PAD, 8'h01, 8'hA5));     // strobe latches
		send_item(make_access(OP_WRITE, ADDR_PAD, 8'hFE, 8'h5A));     // no latch, index clears
		repeat (9)
			send_item(make_access(OP_READ, ADDR_PAD, 8'h00, 8'h00));  // ninth read returns 1
		send_item(make_access(OP_WRITE, ADDR_GAP_BASE, 8'h77, 8'h00));
		send_item(make_access(OP_READ, 16'h5FFF, 8'h00, 8'h00));
		send_item(make_access(OP_WRITE, 16'h7FFF, 8'h3C, 8'h00));
		send_item(make_access(OP_READ, 16'h7FFF, 8'h00, 8'h00));
		send_item(make_access(OP_READ, ADDR_PRG_BASE, 8'h00, 8'h00));
		send_item(make_access(OP_READ, ADDR_ROM_BASE, 8'h00, 8'h00));
		send_item(make_access(OP_WRITE, 16'hFFFF, 8'h00, 8'h00));
		drain();

		// random part, one ROM map setting per phase
		for (p = 0; p < NUM_SETTINGS; p++) begin
			if (p < NUM_FIXED) begin
				mask  = MAP_MASK[p];
				shift = MAP_SHIFT[p];
			end else begin
				mask  = 16'($urandom);
				shift = 4'($urandom_range(0, 15));
			end
			configure(mask, shift);
			steady <= (p == STEADY_PHASE);
			start = items_sent;
			while (items_sent - start < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 99) < 8)
					pad_sequence();
				else
					send_item(random_access());
			end
			steady <= 1'b0;
			drain();
		end

		$display("Ran %0d bus items over %0d ROM map settings, %0d results checked.",
			items_sent, NUM_SETTINGS + 1, sb.checked);
		$display("Targets: ram %0d prgram %0d pad %0d ppu %0d apu %0d",
			sb.target_hits[T_RAM], sb.target_hits[T_PRGRAM], sb.target_hits[T_PAD],
			sb.target_hits[T_PPU], sb.target_hits[T_APU]);
		$display("         rom %0d mapper %0d dma %0d gap %0d",
			sb.target_hits[T_ROM], sb.target_hits[T_MAPPER], sb.target_hits[T_DMA],
			sb.target_hits[T_UNMAPPED]);
		if (sb.errors == 0) begin
			$display("console_cpu_bus_decoder verification clean");
		end else begin
			$display("console_cpu_bus_decoder verification failed");
		end
		$finish;
	end

	// watchdog, far beyond the sweep plus the slowest stalls
	initial begin
		#400_000;
		$display("console_cpu_bus_decoder verification failed");
		$finish;
	end

endmodule
